[sv/gpio_edge_interrupt_controller_defines.svh]
// ----------------------------------------------------------------------------
// GPIO edge interrupt controller assertion macros
// Shared property wrappers, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GPIO_EDGE_INTERRUPT_CONTROLLER_DEFINES_SVH
`define GPIO_EDGE_INTERRUPT_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define GEIC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gpio_edge_interrupt_controller: check failed");

// Next-cycle implication.
`define GEIC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gpio_edge_interrupt_controller: check failed");

`endif

[sv/gpio_eic_pkg.sv]
// ----------------------------------------------------------------------------
// GPIO edge interrupt controller package
// Item and result types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package gpio_eic_pkg;

    localparam int DATA_W        = 8;
    localparam int PIN_COUNT_DEF = 8;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_LEVEL  = 3'd0,
        REG_DIR    = 3'd1,
        REG_SET    = 3'd2,
        REG_CLEAR  = 3'd3,
        REG_RISE   = 3'd4,
        REG_FALL   = 3'd5,
        REG_MASK   = 3'd6,
        REG_STATUS = 3'd7
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        reg_idx_t            reg_index;
        logic [DATA_W-1:0]   write_data;
        logic [DATA_W-1:0]   pin_levels;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [DATA_W-1:0]   pin_drive;
        logic [DATA_W-1:0]   pin_drive_enable;
        logic                irq;
    } result_t;

    // Interrupt-side state, seen by the top level for checking.
    typedef struct packed {
        logic [DATA_W-1:0]   status;
        logic [DATA_W-1:0]   mask;
    } irq_view_t;

endpackage

[sv/gpio_edge_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// GPIO edge interrupt controller
// Eight-register GPIO block with edge-triggered interrupt status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one item per transfer, either a register
//   read, a register write, a pin sample tick carrying the pin levels, or a no-op.
//   Result channel (m_valid/m_ready): exactly one result per item, in order,
//   with read data (zero unless a read), the output latch, the direction
//   bits and the interrupt line, all as they stand after the item.
//   Path: the input register holds the item while the core forms the result
//   for the result register, which raises m_valid once it is loaded.
//   Throughput: one item per cycle while m_ready stays high; the input
//   register and result register both stream.
//   Stall: when m_ready is low the result register holds, the core stops,
//   and the input register absorbs one more item before s_ready drops.
//   Reset: aresetn (synchronous, active low) clears all core registers, all pins
//   to inputs, all interrupts masked, and empties both stages.
// ----------------------------------------------------------------------------
`include "gpio_edge_interrupt_controller_defines.svh"

module gpio_edge_interrupt_controller
    import gpio_eic_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [2:0]        s_reg_index,
    input  logic [DATA_W-1:0] s_write_data,
    input  logic [DATA_W-1:0] s_pin_levels,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic [DATA_W-1:0] m_pin_drive,
    output logic [DATA_W-1:0] m_pin_drive_enable,
    output logic              m_irq
);

    item_t     s_item;
    item_t     item;
    logic      item_valid;
    logic      out_ready;
    logic      fire;
    result_t   core_result;
    result_t   m_result;
    irq_view_t irq_view;

    assign s_item.kind       = kind_t'(s_kind);
    assign s_item.reg_index  = reg_idx_t'(s_reg_index);
    assign s_item.write_data = s_write_data;
    assign s_item.pin_levels = s_pin_levels;

    // Advance the held item into the result register.
    assign fire = item_valid && out_ready;

    gpio_eic_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    gpio_eic_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (item),
        .result   (core_result),
        .irq_view (irq_view)
    );

    gpio_eic_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (core_result),
        .ready    (out_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_read_data        = m_result.read_data;
    assign m_pin_drive        = m_result.pin_drive;
    assign m_pin_drive_enable = m_result.pin_drive_enable;
    assign m_irq              = m_result.irq;

    // Only reads return data.
    `GEIC_ASSERT_NEXT(a_rdata_zero, aclk, aresetn, fire && item.kind != KIND_READ, m_read_data == '0)
    // Shown interrupt line matches the live status and mask while a result is held.
    `GEIC_ASSERT_IMPL(a_irq_live, aclk, aresetn, m_valid, m_irq == |(irq_view.status & irq_view.mask))
    // Input back-pressure only when both stages are full.
    `GEIC_ASSERT_IMPL(a_ready_full, aclk, aresetn, !s_ready, item_valid && m_valid && !m_ready)

endmodule

[sv/gpio_eic_in_stage.sv]
// ----------------------------------------------------------------------------
// GPIO edge interrupt controller input stage
// Registers one incoming transfer and hands it on when the core can take it.
// ----------------------------------------------------------------------------
module gpio_eic_in_stage
    import gpio_eic_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept whenever the held item leaves in the same cycle or none is held.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/gpio_eic_core.sv]
// ----------------------------------------------------------------------------
// GPIO edge interrupt controller core
// Register file, edge detection and result formation for one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module gpio_eic_core
    import gpio_eic_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  item_t     item,
    output result_t   result,
    output irq_view_t irq_view
);

    // Pins beyond the port width can never be written or sampled.
    localparam int PW = (PIN_COUNT < DATA_W) ? PIN_COUNT : DATA_W;

    logic [PW-1:0] out_latch_reg,   out_latch_next;
    logic [PW-1:0] direction_reg,   direction_next;
    logic [PW-1:0] rise_en_reg,     rise_en_next;
    logic [PW-1:0] fall_en_reg,     fall_en_next;
    logic [PW-1:0] irq_mask_reg,    irq_mask_next;
    logic [PW-1:0] irq_status_reg,  irq_status_next;
    logic [PW-1:0] last_pins_reg,   last_pins_next;

    logic [PW-1:0] data;
    logic [PW-1:0] pins;
    logic [PW-1:0] rdata;
    logic [PW-1:0] edges;

    assign data  = item.write_data[PW-1:0];
    assign pins  = item.pin_levels[PW-1:0];
    assign edges = (pins & ~last_pins_reg & rise_en_reg)
                 | (~pins & last_pins_reg & fall_en_reg);

    always_comb begin
        out_latch_next  = out_latch_reg;
        direction_next  = direction_reg;
        rise_en_next    = rise_en_reg;
        fall_en_next    = fall_en_reg;
        irq_mask_next   = irq_mask_reg;
        irq_status_next = irq_status_reg;
        last_pins_next  = last_pins_reg;
        rdata           = '0;

        case (item.kind)
            KIND_READ: begin
                case (item.reg_index)
                    REG_LEVEL:  rdata = (direction_reg & out_latch_reg)
                                      | (~direction_reg & last_pins_reg);
                    REG_DIR:    rdata = direction_reg;
                    REG_RISE:   rdata = rise_en_reg;
                    REG_FALL:   rdata = fall_en_reg;
                    REG_MASK:   rdata = irq_mask_reg;
                    REG_STATUS: rdata = irq_status_reg;
                    default:    rdata = '0;
                endcase
            end
            KIND_WRITE: begin
                case (item.reg_index)
                    REG_DIR:    direction_next  = data;
                    REG_SET:    out_latch_next  = out_latch_reg | data;
                    REG_CLEAR:  out_latch_next  = out_latch_reg & ~data;
                    REG_RISE:   rise_en_next    = data;
                    REG_FALL:   fall_en_next    = data;
                    REG_MASK:   irq_mask_next   = data;
                    REG_STATUS: irq_status_next = irq_status_reg & ~data;
                    default:    ;
                endcase
            end
            KIND_TICK: begin
                irq_status_next = irq_status_reg | edges;
                last_pins_next  = pins;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_latch_reg  <= '0;
            direction_reg  <= '0;
            rise_en_reg    <= '0;
            fall_en_reg    <= '0;
            irq_mask_reg   <= '0;
            irq_status_reg <= '0;
            last_pins_reg  <= '0;
        end else if (fire) begin
            out_latch_reg  <= out_latch_next;
            direction_reg  <= direction_next;
            rise_en_reg    <= rise_en_next;
            fall_en_reg    <= fall_en_next;
            irq_mask_reg   <= irq_mask_next;
            irq_status_reg <= irq_status_next;
            last_pins_reg  <= last_pins_next;
        end
    end

    // Report the state as it stands after this item.
    always_comb begin
        result                             = '0;
        result.read_data[PW-1:0]           = rdata;
        result.pin_drive[PW-1:0]           = out_latch_next;
        result.pin_drive_enable[PW-1:0]    = direction_next;
        result.irq                         = |(irq_status_next & irq_mask_next);
    end

    always_comb begin
        irq_view                = '0;
        irq_view.status[PW-1:0] = irq_status_reg;
        irq_view.mask[PW-1:0]   = irq_mask_reg;
    end

endmodule

[sv/gpio_eic_out_stage.sv]
// ----------------------------------------------------------------------------
// GPIO edge interrupt controller result register
// Holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module gpio_eic_out_stage
    import gpio_eic_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held result leaves this cycle.
    assign ready      = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
